FILE: design/swm_pkg.sv
// Shared constants and link types for the sliding window median block.
// Used by the window store, the sort cell, the sort chain and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int DATA_W     = 32;
   localparam int CFG_W      = 7;
   localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W      = (LEN_W > CFG_W) ? LEN_W : CFG_W;

   localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(3);

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef struct packed {
      logic       valid;
      sample_type data;
   } cell_link_type;

   typedef struct packed {
      logic       full;
      sample_type data;
   } cell_hold_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: design/swm_window_store.sv
// Arrival-order store of the latest samples, one write and one registered read per cycle.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_window_store (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [swm_pkg::PTR_W-1:0] wr_addr,
   input  wire  swm_pkg::sample_type wr_data,
   input  wire  [swm_pkg::PTR_W-1:0] rd_addr,
   output swm_pkg::sample_type       rd_data
);
   import swm_pkg::*;

   sample_type store_mem [WINDOW_MAX];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/swm_sort_cell.sv
// One cell of the insertion sort chain: keeps the smaller value, passes the larger right.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_sort_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  swm_pkg::cell_ctrl_type ctrl,
   input  wire  swm_pkg::cell_link_type link_in,
   output swm_pkg::cell_link_type       link_out,
   input  wire  swm_pkg::cell_hold_type right_hold,
   output swm_pkg::cell_hold_type       hold_out
);
   import swm_pkg::*;

   logic       full_ff, full_in;
   sample_type held_ff, held_in;
   logic       pass_valid_ff, pass_valid_in;
   sample_type pass_data_ff, pass_data_in;

   always_comb begin
      full_in       = full_ff;
      held_in       = held_ff;
      pass_valid_in = 1'b0;
      pass_data_in  = pass_data_ff;
      if (ctrl.clear) begin
         full_in = 1'b0;
      end else if (ctrl.shift) begin
         full_in = right_hold.full;
         held_in = right_hold.data;
      end else if (link_in.valid) begin
         if (!full_ff) begin
            full_in = 1'b1;
            held_in = link_in.data;
         end else if (link_in.data < held_ff) begin
            held_in       = link_in.data;
            pass_valid_in = 1'b1;
            pass_data_in  = held_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_data_in  = link_in.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         full_ff       <= full_in;
         pass_valid_ff <= pass_valid_in;
      end
      held_ff      <= held_in;
      pass_data_ff <= pass_data_in;
   end

   assign link_out.valid = pass_valid_ff;
   assign link_out.data  = pass_data_ff;
   assign hold_out.full  = full_ff;
   assign hold_out.data  = held_ff;

endmodule

`default_nettype wire

FILE: design/swm_sort_chain.sv
// Row of sort cells that orders the window, then shifts towards the head to pick a rank.
// Depends on swm_pkg and swm_sort_cell.
`timescale 1ns / 1ps
`default_nettype none

module swm_sort_chain (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  swm_pkg::cell_ctrl_type ctrl,
   input  wire  swm_pkg::cell_link_type feed,
   output swm_pkg::sample_type          head_data,
   output logic                         busy
);
   import swm_pkg::*;

   cell_link_type links [WINDOW_MAX+1];
   cell_hold_type holds [WINDOW_MAX+1];

   assign links[0]          = feed;
   assign holds[WINDOW_MAX] = '{full: 1'b0, data: '0};

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_sort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .link_in    (links[i]),
         .link_out   (links[i+1]),
         .right_hold (holds[i+1]),
         .hold_out   (holds[i])
      );
   end

   always_comb begin
      busy = 1'b0;
      for (int i = 1; i <= WINDOW_MAX; i++) begin
         busy = busy | links[i].valid;
      end
   end

   assign head_data = holds[0].data;

endmodule

`default_nettype wire

FILE: design/sliding_window_median.sv
// Top level of the sliding window median filter: handshakes, window bookkeeping and sequencing.
// Depends on swm_pkg, swm_window_store and swm_sort_chain.
//
//   channel  direction  transfer condition          carries
//   req_     in         req_valid && req_ready      sample, start_req
//   rsp_     out        rsp_valid && rsp_ready      median_value
//   csr_     in         csr_wr_en                   window_len (7 bits)
//
// A sample that completes no full window leaves the sequencer idle. For a sample that gives
// a median, the sort chain is fed one window sample per cycle from the single read port of
// the store, then settles and shifts the chosen rank to its head. Reset clears the control
// state only; the store holds no defined data until written. A result waiting on rsp_ready
// holds the next median back, but the next request is taken as soon as the sequencer is free.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  swm_pkg::sample_type req_sample,
   input  wire                       req_start_req,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output swm_pkg::sample_type       rsp_median_value,
   input  wire                       csr_wr_en,
   input  wire  [swm_pkg::CFG_W-1:0] csr_wr_data
);
   import swm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FEED  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_SHIFT = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] window_len_ff;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [PTR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [LEN_W-1:0] shift_cnt_ff, shift_cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_data_ff, rsp_data_in;

   logic             accept;
   logic [CMP_W-1:0] raw_len;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] fill_eff;
   logic [PTR_W-1:0] ptr_eff;
   logic [LEN_W-1:0] ptr_ext;
   logic [PTR_W-1:0] base_addr;
   sample_type       rd_data;
   sample_type       head_data;
   logic             chain_busy;
   cell_ctrl_type    chain_ctrl;
   cell_link_type    chain_feed;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      raw_len = CMP_W'(window_len_ff);
      if (raw_len == '0) begin
         eff_len = LEN_W'(1);
      end else if (raw_len > CMP_W'(WINDOW_MAX)) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = LEN_W'(raw_len);
      end
   end

   assign fill_eff = req_start_req ? '0 : fill_ff;
   assign ptr_eff  = req_start_req ? '0 : ptr_ff;

   always_comb begin
      ptr_ext = LEN_W'(ptr_eff) + LEN_W'(1);
      if (ptr_ext >= eff_len) begin
         base_addr = PTR_W'(ptr_ext - eff_len);
      end else begin
         base_addr = PTR_W'(ptr_ext + LEN_W'(WINDOW_MAX) - eff_len);
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      len_in       = len_ff;
      rd_addr_in   = rd_addr_ff;
      issue_cnt_in = issue_cnt_ff;
      shift_cnt_in = shift_cnt_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      chain_ctrl   = '{clear: 1'b0, shift: 1'b0};

      if (accept) begin
         ptr_in = (ptr_eff == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_eff + PTR_W'(1);
      end
      if (accept && fill_eff < LEN_W'(WINDOW_MAX)) begin
         fill_in = fill_eff + LEN_W'(1);
      end else if (accept) begin
         fill_in = fill_eff;
      end

      case (state_ff)
         S_IDLE: begin
            chain_ctrl.clear = 1'b1;
            if (accept && fill_in >= eff_len) begin
               state_in     = S_FEED;
               len_in       = eff_len;
               rd_addr_in   = base_addr;
               issue_cnt_in = '0;
            end
         end
         S_FEED: begin
            rd_pend_in   = 1'b1;
            rd_addr_in   = (rd_addr_ff == PTR_W'(WINDOW_MAX - 1)) ? '0
                                                                  : rd_addr_ff + PTR_W'(1);
            issue_cnt_in = issue_cnt_ff + LEN_W'(1);
            if (issue_cnt_ff == len_ff - LEN_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_pend_ff && !chain_busy) begin
               state_in     = S_SHIFT;
               shift_cnt_in = (len_ff - LEN_W'(1)) >> 1;
            end
         end
         S_SHIFT: begin
            if (shift_cnt_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               chain_ctrl.shift = 1'b1;
               shift_cnt_in     = shift_cnt_ff - LEN_W'(1);
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = head_data;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign chain_feed.valid = rd_pend_ff;
   assign chain_feed.data  = rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         window_len_ff <= WINDOW_LEN_RESET;
         fill_ff       <= '0;
         ptr_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_len_ff <= csr_wr_data;
         end
      end
      len_ff       <= len_in;
      rd_addr_ff   <= rd_addr_in;
      issue_cnt_ff <= issue_cnt_in;
      shift_cnt_ff <= shift_cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   swm_window_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_eff),
      .wr_data (req_sample),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   swm_sort_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .feed      (chain_feed),
      .head_data (head_data),
      .busy      (chain_busy)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_data_ff;

endmodule

`default_nettype wire

FILE: tb/tb_sliding_window_median.sv
// Self-checking testbench for sliding_window_median: directed bursts, then random phases
// with varied window lengths, idling and a long receiver hold-off, checked against a predictor.
// Depends on swm_pkg and the sliding_window_median top level.
`timescale 1ns / 1ps

module tb_sliding_window_median;
   import swm_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_HOLD     = 400;
   localparam sample_type SAMPLE_MAX = sample_type'(32'h7FFF_FFFF);
   localparam sample_type SAMPLE_MIN = sample_type'(32'h8000_0000);

   typedef struct {
      sample_type value;
      logic       restart;
   } window_item_type;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_ready;
   sample_type       req_sample    = '0;
   logic             req_start_req = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready     = 1'b0;
   sample_type       rsp_median_value;
   logic             csr_wr_en     = 1'b0;
   logic [CFG_W-1:0] csr_wr_data   = '0;

   window_item_type  pending_samples[$];
   window_item_type  next_item;
   sample_type       medians_due[$];
   sample_type       expected_median;

   sample_type       window_ring[WINDOW_MAX];
   int               window_fill    = 0;
   int               window_head    = 0;
   logic [CFG_W-1:0] window_len_cfg = WINDOW_LEN_RESET;

   int   samples_queued = 0;
   int   samples_taken  = 0;
   int   mismatches     = 0;
   int   quiet_cycles   = 0;
   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   int   rsp_hold_left  = 0;
   logic sample_taken   = 1'b0;

   sliding_window_median u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_value (rsp_median_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Predicts the lower median of the most recent samples for one accepted transfer.
   task automatic slide_window(input sample_type value, input logic restart);
      sample_type ordered[WINDOW_MAX];
      sample_type v;
      int span, first, pos;
      if (restart) begin
         window_fill = 0;
         window_head = 0;
      end
      window_ring[window_head] = value;
      window_head = (window_head + 1) % WINDOW_MAX;
      if (window_fill < WINDOW_MAX) window_fill++;
      if (window_len_cfg == 0) span = 1;
      else if (window_len_cfg > WINDOW_MAX) span = WINDOW_MAX;
      else span = int'(window_len_cfg);
      if (window_fill >= span) begin
         first = (window_head + WINDOW_MAX - span) % WINDOW_MAX;
         for (int k = 0; k < span; k++) begin
            v = window_ring[(first + k) % WINDOW_MAX];
            pos = k;
            while (pos > 0 && v < ordered[pos-1]) begin
               ordered[pos] = ordered[pos-1];
               pos--;
            end
            ordered[pos] = v;
         end
         medians_due.insert(medians_due.size(), ordered[(span - 1) / 2]);
      end
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return sample_type'($urandom);
         5, 6, 7:       return sample_type'(int'($urandom_range(0, 16)) - 8);
         8: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1)) return SAMPLE_MAX - sample_type'($urandom_range(0, 3));
            else return SAMPLE_MIN + sample_type'($urandom_range(0, 3));
         end
      endcase
   endfunction

   // Called just after a rising edge, so the driver never races with a push.
   task automatic queue_sample(input sample_type value, input logic restart);
      pending_samples.insert(pending_samples.size(), '{value, restart});
      samples_queued++;
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (samples_taken != samples_queued || medians_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_len(input logic [CFG_W-1:0] len_value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len_value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input int len_value, input int count, input int idle_pct,
                            input int stall_pct, input logic first_restart,
                            input int restart_pct, input int hold_cycles);
      wait_for_drain();
      write_window_len(CFG_W'(len_value));
      @(posedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      rsp_hold_left = hold_cycles;
      for (int i = 0; i < count; i++) begin
         queue_sample(pick_sample(),
                      (i == 0) ? first_restart : ($urandom_range(0, 99) < restart_pct));
      end
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_valid || sample_taken)) begin
         if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item = pending_samples.pop_front();
            req_valid     <= 1'b1;
            req_sample    <= next_item.value;
            req_start_req <= next_item.restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         sample_taken = req_valid && req_ready;
         if (csr_wr_en) window_len_cfg = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (medians_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: median %0d arrived with none expected", rsp_median_value);
            end else begin
               expected_median = medians_due.pop_front();
               if (rsp_median_value !== expected_median) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: median_value expected %0d, got %0d",
                              expected_median, rsp_median_value);
               end
            end
         end
         if (sample_taken) begin
            slide_window(req_sample, req_start_req);
            samples_taken++;
         end
         if (sample_taken || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else if (++quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset window length of three: extremes, sign changes and a restart mid-sequence.
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample('0, 1'b0);
      queue_sample('1, 1'b0);
      queue_sample(sample_type'(1), 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(sample_type'(5), 1'b1);
      queue_sample(sample_type'(6), 1'b0);
      queue_sample(sample_type'(4), 1'b0);

      // A zero length behaves as a window of one.
      wait_for_drain();
      write_window_len(CFG_W'(0));
      @(posedge clock);
      queue_sample(sample_type'(42), 1'b1);
      queue_sample(sample_type'(-7), 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);

      // Growing the window mid-sequence uses the samples already held.
      wait_for_drain();
      write_window_len(CFG_W'(2));
      @(posedge clock);
      queue_sample(sample_type'(3), 1'b0);
      queue_sample(sample_type'(-3), 1'b0);
      queue_sample(sample_type'(3), 1'b0);

      run_phase(64,  100, 0,  0,  1'b0, 1, 0);
      run_phase(5,   110, 50, 0,  1'b0, 4, 0);
      run_phase(127, 90,  0,  50, 1'b1, 0, 0);
      run_phase(1,   80,  26, 26, 1'b1, 5, 0);
      run_phase(7,   110, 0,  50, 1'b1, 4, LONG_HOLD);
      run_phase(0,   60,  50, 0,  1'b0, 5, 0);
      run_phase(3,   110, 26, 26, 1'b0, 5, 0);
      run_phase(16,  90,  0,  0,  1'b1, 3, 0);
      run_phase(40,  70,  50, 50, 1'b1, 2, 0);
      wait_for_drain();

      if (mismatches == 0 && medians_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
